// ===== design/oli_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered list package
// Sizes, request and status codes, and the transfer payload types shared by
// the ordered list block and its testbench.
// ----------------------------------------------------------------------------
package oli_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_DUMP   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic        [1:0]  req_type;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] item_out;
    logic               last;
    logic        [4:0]  count;
  } out_t;

endpackage

// ===== design/oli_ram.sv =====
// ----------------------------------------------------------------------------
// Ordered list RAM
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module oli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ordered_list_insert_remove.sv =====
// ----------------------------------------------------------------------------
// Ordered list with insert, remove and dump
// Keeps up to DEPTH signed 32-bit items in insertion order in a small RAM and
// serves insert, remove-first-match and dump requests under a sequencer.
// ----------------------------------------------------------------------------
// A request is transferred at a rising edge where start is high and busy is
// low. Results appear on out_data for exactly one cycle each, flagged by
// out_valid, and the receiver must take them as they come. An insert, any
// request on an empty list and an unused request code leave busy low; the
// insert and the empty-list request give their single result in the cycle
// after the transfer, and an unused code gives no result at all. A remove
// keeps busy high while it reads the entries from the head, one at a time,
// up to the first match, and then while it reads each later entry and writes
// it back one place lower; a match on the tail item needs no such move. A
// remove that finds nothing keeps busy high until it has checked the tail
// item. A dump keeps busy high while it reads the list and delivers its
// results in consecutive cycles, the first after the state change, the RAM
// read and the output register. A remove or a dump gives its final result
// in the first cycle with busy low. The search, the shift and the dump all
// pass through the RAM's single registered read port, one entry per cycle.
// The worst case is a remove that matches in a full list.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove
  import oli_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_DUMP
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  // ptr_r is the next address to read; it can reach count, so it is wider
  // than an address and drives the RAM through a part-select.
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  // chk_r is the index whose read data is in flight (search, dump) or the
  // entry being overwritten (shift).
  logic [IDX_W-1:0]   chk_r, chk_nxt;
  logic               pend_r, pend_nxt;
  logic signed [31:0] value_r, value_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [31:0]        ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [31:0]        ram_rdata;

  logic               chk_is_tail;
  logic               more_reads;

  oli_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The comparator pair of the sequences: search and dump use both, shift only more_reads.
  assign chk_is_tail = ((CNT_W'(chk_r) + CNT_W'(1)) == count_r);
  assign more_reads  = (ptr_r < count_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    chk_nxt       = chk_r;
    pend_nxt      = 1'b0;
    value_nxt     = value_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = chk_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = ptr_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          value_nxt = in_data.value;
          ptr_nxt   = '0;
          out_data_nxt.item_out = '0;
          out_data_nxt.last     = 1'b1;
          out_data_nxt.count    = 5'(count_r);
          case (in_data.req_type) inside
            REQ_INSERT: begin
              out_valid_nxt = 1'b1;
              if (count_r == CNT_W'(DEPTH)) begin
                out_data_nxt.status = ST_FULL;
              end else begin
                ram_we              = 1'b1;
                ram_waddr           = count_r[IDX_W-1:0];
                ram_wdata           = in_data.value;
                count_nxt           = count_r + CNT_W'(1);
                out_data_nxt.status = ST_OK;
                out_data_nxt.count  = 5'(count_nxt);
              end
            end
            REQ_REMOVE, REQ_DUMP: begin
              if (count_r == '0) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = ST_EMPTY;
              end else if (in_data.req_type == REQ_REMOVE) begin
                state_nxt = S_SEARCH;
              end else begin
                state_nxt = S_DUMP;
              end
            end
            default: begin
              // Unused request code: no result and no change.
            end
          endcase
        end
      end

      S_SEARCH: begin
        if (pend_r && (ram_rdata == value_r)) begin
          // First match found: close the gap from here on.
          state_nxt = S_SHIFT;
          ptr_nxt   = CNT_W'(chk_r) + CNT_W'(1);
        end else if (pend_r && chk_is_tail) begin
          state_nxt             = S_IDLE;
          out_valid_nxt         = 1'b1;
          out_data_nxt.status   = ST_NOTFOUND;
          out_data_nxt.item_out = '0;
          out_data_nxt.last     = 1'b1;
          out_data_nxt.count    = 5'(count_r);
        end else if (more_reads) begin
          pend_nxt = 1'b1;
          chk_nxt  = ptr_r[IDX_W-1:0];
          ptr_nxt  = ptr_r + CNT_W'(1);
        end
      end

      S_SHIFT: begin
        // Read entry ptr while writing the previous read back one place lower.
        if (pend_r) begin
          ram_we  = 1'b1;
          chk_nxt = chk_r + IDX_W'(1);
        end
        if (more_reads) begin
          pend_nxt = 1'b1;
          ptr_nxt  = ptr_r + CNT_W'(1);
        end else if (!pend_r) begin
          state_nxt             = S_IDLE;
          count_nxt             = count_r - CNT_W'(1);
          out_valid_nxt         = 1'b1;
          out_data_nxt.status   = ST_OK;
          out_data_nxt.item_out = '0;
          out_data_nxt.last     = 1'b1;
          out_data_nxt.count    = 5'(count_nxt);
        end
      end

      S_DUMP: begin
        if (pend_r) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.status   = ST_OK;
          out_data_nxt.item_out = ram_rdata;
          out_data_nxt.last     = chk_is_tail;
          out_data_nxt.count    = 5'(count_r);
          if (chk_is_tail) begin
            state_nxt = S_IDLE;
          end
        end
        if (more_reads) begin
          pend_nxt = 1'b1;
          chk_nxt  = ptr_r[IDX_W-1:0];
          ptr_nxt  = ptr_r + CNT_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r      <= ptr_nxt;
    chk_r      <= chk_nxt;
    value_r    <= value_nxt;
    out_data_r <= out_data_nxt;
  end

  // The list never holds more than the store's depth.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("item count exceeds depth");

  // An accepted insert gives its single result in the next cycle.
  a_insert_result : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.req_type == REQ_INSERT)) |=>
      (out_valid && out_data.last))
    else $error("insert result missing");

  // Dump results follow one another without gaps until the last.
  a_dump_burst : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |=> out_valid)
    else $error("gap inside dump burst");

  // A full status is only reported with the store at its depth.
  a_full_count : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_FULL)) |-> (out_data.count == 5'(DEPTH)))
    else $error("full status with list not full");

endmodule

// ===== dv/ordered_list_insert_remove_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list insert/remove/dump testbench
// Drives insert, remove and dump requests into the ordered list block, keeps
// a mirror of the list contents and checks every result field by field.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove_test
  import oli_pkg::*;
;

  // The request code that the block must ignore without any result.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 360;
  localparam int unsigned CALM_TAIL    = 60;
  // The drain wait covers the worst request, a remove that matches in a full
  // list, twice over.
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 8;
  // The limit lies far above what roughly 400 requests need at worst, idle
  // gaps included.
  localparam int unsigned LIMIT_CYCLES = 200000;

  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  // --------------------------------------------------------------------------
  // Mirror of the list. Each accepted request updates the mirror and queues
  // the results that it should cause; each result from the block is compared
  // with the oldest queued one.
  // --------------------------------------------------------------------------
  class list_mirror;
    logic signed [31:0] held_items[$];
    out_t               due_results[$];
    int unsigned        error_count;

    function out_t make_result(logic [1:0] status, logic signed [31:0] item, logic last);
      out_t r;
      r.status   = status;
      r.item_out = item;
      r.last     = last;
      r.count    = 5'(held_items.size());
      return r;
    endfunction

    function void note_request(in_t req);
      int hit;
      hit = -1;
      case (req.req_type)
        REQ_INSERT: begin
          if (held_items.size() >= DEPTH) begin
            due_results.push_back(make_result(ST_FULL, '0, 1'b1));
          end else begin
            held_items.push_back(req.value);
            due_results.push_back(make_result(ST_OK, '0, 1'b1));
          end
        end
        REQ_REMOVE: begin
          if (held_items.size() == 0) begin
            due_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
          end else begin
            // The first match from the head goes; the rest keep their order.
            foreach (held_items[i]) begin
              if (hit < 0 && held_items[i] == req.value) hit = i;
            end
            if (hit < 0) begin
              due_results.push_back(make_result(ST_NOTFOUND, '0, 1'b1));
            end else begin
              held_items.delete(hit);
              due_results.push_back(make_result(ST_OK, '0, 1'b1));
            end
          end
        end
        REQ_DUMP: begin
          if (held_items.size() == 0) begin
            due_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
          end else begin
            foreach (held_items[i]) begin
              due_results.push_back(make_result(ST_OK, held_items[i],
                                                i == held_items.size() - 1));
            end
          end
        end
        default: begin
          // An unused code is dropped: no result and no change.
        end
      endcase
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: status %0d item_out %0d last %0d count %0d",
               got.status, got.item_out, got.last, got.count);
        error_count++;
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        error_count++;
      end
      if (got.item_out !== want.item_out) begin
        $error("item_out: expected %0d, actual %0d", want.item_out, got.item_out);
        error_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        error_count++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, actual %0d", want.count, got.count);
        error_count++;
      end
    endfunction
  endclass

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         in_data = '0;
  logic        out_valid;
  out_t        out_data;

  list_mirror  mirror;
  int unsigned cycle_count = 0;

  // Values inserted lately, so that removes mostly hit something held and
  // inserts sometimes repeat a value already in the list.
  logic signed [31:0] recent_values[$];

  ordered_list_insert_remove dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Everything is sampled at the rising edge, before the block's own updates
  // of that edge take effect. Results are checked before the transfer of the
  // same edge is noted: a result always belongs to an earlier request.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1) mirror.check_result(out_data);
      if (start === 1'b1 && busy === 1'b0) mirror.note_request(in_data);
    end
  end

  // Watchdog: a hung block or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("ordered_list_insert_remove_test failed");
      $finish;
    end
  end

  // Presents one request, after an optional idle gap, and returns at the edge
  // where it is transferred. Start is left high, so that a request that
  // follows with no gap is presented back to back.
  task automatic drive_request(input logic [1:0] kind, input logic signed [31:0] val,
                               input int unsigned gap);
    in_t req;
    req.req_type = kind;
    req.value    = val;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy !== 1'b0);
    if (kind == REQ_INSERT) begin
      recent_values.push_back(val);
      if (recent_values.size() > 24) void'(recent_values.pop_front());
    end
  endtask

  // Idle bursts for about one request in three, none when calm is set.
  function automatic int unsigned pick_gap(bit calm);
    if (calm || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(1, 7);
  endfunction

  function automatic logic signed [31:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  // hit_pct is the chance of reusing a recently inserted value.
  function automatic logic signed [31:0] pick_value(int unsigned hit_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < hit_pct && recent_values.size() != 0) begin
      return recent_values[$urandom_range(0, recent_values.size() - 1)];
    end
    if (roll < hit_pct + 8) return pick_extreme();
    return $urandom;
  endfunction

  // Directed opening: the empty list, the value extremes, a duplicate, a miss,
  // the ignored code, a full list and a remove at the head of a full list.
  task automatic run_directed();
    drive_request(REQ_DUMP,    32'sd0, 0);
    drive_request(REQ_REMOVE,  32'sd5, pick_gap(1'b0));
    drive_request(REQ_UNUSED,  32'sd7, 0);
    drive_request(REQ_INSERT,  32'sh8000_0000, pick_gap(1'b0));
    drive_request(REQ_INSERT,  32'sh7fff_ffff, 0);
    drive_request(REQ_INSERT,  32'sd0, pick_gap(1'b0));
    drive_request(REQ_INSERT,  -32'sd1, 0);
    drive_request(REQ_INSERT,  32'sd0, 0);
    // Two zeros are held; only the first one from the head may go.
    drive_request(REQ_REMOVE,  32'sd0, 0);
    drive_request(REQ_REMOVE,  32'sd12345, pick_gap(1'b0));
    drive_request(REQ_UNUSED,  -32'sd1, 0);
    // Four items are held now; twelve more fill the list.
    for (int k = 0; k < 12; k++) begin
      drive_request(REQ_INSERT, 32'sh0101_0101 * (k + 1), pick_gap(1'b0));
    end
    drive_request(REQ_INSERT,  32'sd99, 0);
    drive_request(REQ_DUMP,    32'sd0, pick_gap(1'b0));
    drive_request(REQ_REMOVE,  32'sh8000_0000, 0);
  endtask

  // Random part in phases that lean towards filling, draining or neither, so
  // that the count sweeps between empty and full. The unused code is mixed in
  // as noise and does not count towards the number of requests.
  task automatic run_random();
    int unsigned done;
    int unsigned phase_left;
    int unsigned insert_pct;
    int unsigned roll;
    int unsigned gap;
    bit          calm_phase;
    mix_t        mix;
    done       = 0;
    phase_left = 0;
    insert_pct = 50;
    calm_phase = 1'b0;
    while (done < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        mix        = mix_t'($urandom_range(0, 2));
        phase_left = $urandom_range(15, 40);
        calm_phase = ($urandom_range(0, 2) == 0);
        case (mix)
          MIX_FILL:  insert_pct = 75;
          MIX_DRAIN: insert_pct = 20;
          default:   insert_pct = 50;
        endcase
      end
      phase_left--;
      // No idling at all over the last part of the run.
      gap  = pick_gap(calm_phase || done >= RANDOM_ITEMS - CALM_TAIL);
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        drive_request(REQ_UNUSED, $urandom, gap);
      end else begin
        if (roll < 15) begin
          drive_request(REQ_DUMP, $urandom, gap);
        end else if ($urandom_range(0, 99) < insert_pct) begin
          drive_request(REQ_INSERT, pick_value(35), gap);
        end else begin
          drive_request(REQ_REMOVE, pick_value(80), gap);
        end
        done++;
      end
    end
  endtask

  initial begin
    mirror = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random();
    start <= 1'b0;

    // Let every expected transfer arrive, then watch a little longer for any
    // result that nobody asked for.
    while (mirror.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mirror.error_count == 0 && mirror.due_results.size() == 0) begin
      $display("ordered_list_insert_remove_test passed");
    end else begin
      $display("ordered_list_insert_remove_test failed");
    end
    $finish;
  end

endmodule
